// File: rtl/pkbl_pkg.sv
package pkbl_pkg;

    // table geometry
    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    // field widths
    localparam int LEVEL_W  = 16;
    localparam int OPTION_W = 16;
    localparam int KEY_W    = 22;
    localparam int TIME_W   = 64;
    localparam int HIT_W    = 16;
    localparam int THR_W    = 16;
    localparam int WIN_W    = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 40;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 2'd1;

    // register reset values
    localparam logic [THR_W-1:0] THRESHOLD_RST = 16'd4;
    localparam logic [WIN_W-1:0] WINDOW_RST    = 40'd1000000000;

    // watched level / option pairs
    localparam logic [LEVEL_W-1:0]  LEVEL_A  = 16'd279;
    localparam logic [OPTION_W-1:0] OPT_A    = 16'd1;
    localparam logic [LEVEL_W-1:0]  LEVEL_B  = 16'd17;
    localparam logic [OPTION_W-1:0] OPT_B    = 16'd100;
    localparam logic [LEVEL_W-1:0]  LEVEL_C  = 16'd278;
    localparam logic [OPTION_W-1:0] OPT_C1   = 16'd1;
    localparam logic [OPTION_W-1:0] OPT_C2   = 16'd2;

    localparam logic [HIT_W-1:0] HIT_MAX = '1;

    // classified item passed from front to back
    typedef struct packed {
        logic              watched;
        logic [KEY_W-1:0]  process_key;
        logic [TIME_W-1:0] time_now;
    } t_job;

    // configuration seen by the back end
    typedef struct packed {
        logic [THR_W-1:0] deny_level;
        logic [WIN_W-1:0] window_ns;
    } t_cfg;

endpackage

// File: rtl/pkbl_req_if.sv
interface pkbl_req_if;
    import pkbl_pkg::*;

    logic                valid;
    logic                ready;
    logic [LEVEL_W-1:0]  level_code;
    logic [OPTION_W-1:0] option_code;
    logic [KEY_W-1:0]    process_key;
    logic [TIME_W-1:0]   time_now;

    modport source (
        output valid, level_code, option_code, process_key, time_now,
        input  ready
    );
    modport sink (
        input  valid, level_code, option_code, process_key, time_now,
        output ready
    );
endinterface

// File: rtl/pkbl_res_if.sv
interface pkbl_res_if;
    logic valid;
    logic ready;
    logic verdict;

    modport source (output valid, verdict, input ready);
    modport sink (input valid, verdict, output ready);
endinterface

// File: rtl/pkbl_front.sv
module pkbl_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    pkbl_req_if.sink                           i_req,
    input  logic                               i_cfg_we,
    input  logic [pkbl_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pkbl_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_full,
    output logic                               o_push,
    output pkbl_pkg::t_job                     o_job,
    output pkbl_pkg::t_cfg                     o_cfg
);
    import pkbl_pkg::*;

    logic [THR_W-1:0] r_threshold;
    logic [WIN_W-1:0] r_window;
    logic             watched;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_window    <= WINDOW_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_THRESHOLD: r_threshold <= i_cfg_data[THR_W-1:0];
                CFG_WINDOW:    r_window    <= i_cfg_data[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // classify the level / option pair
    always_comb begin
        watched = ((i_req.level_code == LEVEL_A) && (i_req.option_code == OPT_A))
               || ((i_req.level_code == LEVEL_B) && (i_req.option_code == OPT_B))
               || ((i_req.level_code == LEVEL_C) && ((i_req.option_code == OPT_C1)
                                                  || (i_req.option_code == OPT_C2)));
    end

    // push every accepted item into the queue
    assign i_req.ready         = !i_full;
    assign o_push              = i_req.valid && !i_full;
    assign o_job.watched       = watched;
    assign o_job.process_key   = i_req.process_key;
    assign o_job.time_now      = i_req.time_now;
    assign o_cfg.deny_level    = r_threshold;
    assign o_cfg.window_ns     = r_window;

endmodule

// File: rtl/pkbl_queue.sv
module pkbl_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pkbl_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output pkbl_pkg::t_job o_job
);
    import pkbl_pkg::*;

    t_job       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_slot[r_rd_ptr];

    // two-slot storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/pkbl_back.sv
module pkbl_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  pkbl_pkg::t_job i_job,
    output logic           o_pop,
    input  pkbl_pkg::t_cfg i_cfg,
    pkbl_res_if.source     o_res
);
    import pkbl_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_LOOK = 5'b00100,
        S_UPD  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    // table memories
    logic [KEY_W-1:0]  key_mem  [TABLE_ENTRIES];
    logic [TIME_W-1:0] time_mem [TABLE_ENTRIES];
    logic [HIT_W-1:0]  hit_mem  [TABLE_ENTRIES];

    t_state            r_state, n_state;
    t_job              r_job, n_job;
    logic [CNT_W-1:0]  r_addr, n_addr;
    logic [IDX_W-1:0]  r_cmp_idx, n_cmp_idx;
    logic              r_cmp_vld, n_cmp_vld;
    logic [CNT_W-1:0]  r_used, n_used;
    logic              r_stale, n_stale;
    logic [HIT_W-1:0]  r_hit_inc, n_hit_inc;
    logic              r_verdict, n_verdict;
    logic              r_out_vld, n_out_vld;
    logic              r_out_verdict, n_out_verdict;

    logic [KEY_W-1:0]  r_key_q;
    logic [TIME_W-1:0] r_time_q;
    logic [HIT_W-1:0]  r_hit_q;

    logic              key_re, ent_re, key_we, ent_we;
    logic [IDX_W-1:0]  wr_idx;
    logic [HIT_W-1:0]  wr_hit;
    logic              hit, issue;
    logic [TIME_W-1:0] gap;

    assign hit   = r_cmp_vld && (r_key_q == r_job.process_key);
    assign issue = (r_addr < r_used);
    assign gap   = r_job.time_now - r_time_q;

    // sequencer
    always_comb begin
        n_state       = r_state;
        n_job         = r_job;
        n_addr        = r_addr;
        n_cmp_idx     = r_cmp_idx;
        n_cmp_vld     = r_cmp_vld;
        n_used        = r_used;
        n_stale       = r_stale;
        n_hit_inc     = r_hit_inc;
        n_verdict     = r_verdict;
        n_out_vld     = r_out_vld && !o_res.ready;
        n_out_verdict = r_out_verdict;
        key_re        = 1'b0;
        ent_re        = 1'b0;
        key_we        = 1'b0;
        ent_we        = 1'b0;
        wr_idx        = r_used[IDX_W-1:0];
        wr_hit        = HIT_W'(1);
        o_pop         = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_pop     = 1'b1;
                    n_job     = i_job;
                    n_addr    = '0;
                    n_cmp_vld = 1'b0;
                    n_verdict = 1'b0;
                    n_state   = i_job.watched ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (hit) begin
                    ent_re  = 1'b1;
                    n_state = S_LOOK;
                end else if (issue) begin
                    key_re    = 1'b1;
                    n_cmp_idx = r_addr[IDX_W-1:0];
                    n_cmp_vld = 1'b1;
                    n_addr    = r_addr + CNT_W'(1);
                end else begin
                    // miss: insert when there is room
                    if (r_used < CNT_W'(TABLE_ENTRIES)) begin
                        key_we = 1'b1;
                        ent_we = 1'b1;
                        n_used = r_used + CNT_W'(1);
                    end
                    n_verdict = 1'b0;
                    n_state   = S_DONE;
                end
            end
            S_LOOK: begin
                n_stale   = (gap > {{(TIME_W-WIN_W){1'b0}}, i_cfg.window_ns});
                n_hit_inc = (r_hit_q == HIT_MAX) ? HIT_MAX : r_hit_q + HIT_W'(1);
                n_state   = S_UPD;
            end
            S_UPD: begin
                ent_we    = 1'b1;
                wr_idx    = r_cmp_idx;
                wr_hit    = r_stale ? HIT_W'(1) : r_hit_inc;
                n_verdict = !r_stale && (r_hit_inc >= i_cfg.deny_level);
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_vld || o_res.ready) begin
                    n_out_vld     = 1'b1;
                    n_out_verdict = r_verdict;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_used    <= '0;
            r_out_vld <= 1'b0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_out_vld <= n_out_vld;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_job         <= n_job;
        r_addr        <= n_addr;
        r_cmp_idx     <= n_cmp_idx;
        r_stale       <= n_stale;
        r_hit_inc     <= n_hit_inc;
        r_verdict     <= n_verdict;
        r_out_verdict <= n_out_verdict;
    end

    // key memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_mem[wr_idx] <= r_job.process_key;
        end
        if (key_re) begin
            r_key_q <= key_mem[r_addr[IDX_W-1:0]];
        end
    end

    // time and count memories
    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            time_mem[wr_idx] <= r_job.time_now;
            hit_mem[wr_idx]  <= wr_hit;
        end
        if (ent_re) begin
            r_time_q <= time_mem[r_cmp_idx];
            r_hit_q  <= hit_mem[r_cmp_idx];
        end
    end

    assign o_res.valid   = r_out_vld;
    assign o_res.verdict = r_out_verdict;

    // fill count never passes the table size
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(TABLE_ENTRIES))
        else $error("fill count beyond table size");

    // every insertion bumps the fill count
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        key_we |=> (r_used == $past(r_used) + CNT_W'(1)))
        else $error("insertion without fill count step");

    // scan address stays inside the filled part
    a_scan_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_addr <= r_used))
        else $error("scan address past fill count");

    // a finished item lands in the output register
    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && (!r_out_vld || o_res.ready)) |=> r_out_vld)
        else $error("result not loaded");

endmodule

// File: rtl/per_key_burst_limiter.sv
// channel   dir   handshake              payload
// i_req     in    valid / ready          level_code, option_code, process_key, time_now
// o_res     out   valid / ready          verdict (0 allow, 1 deny)
// i_cfg     in    i_cfg_we, no wait      i_cfg_idx, i_cfg_data
//
// a watched item is searched by the key memory read port, which scans one stored
// key per cycle until a hit or the fill count, then lookup, update and result follow.
// an item outside the watched pairs skips the search and goes straight to result.
// reset clears the fill count and control registers; no clearing pass over the table.
// a 2-item queue parts intake from the search, and the output register lets
// the next item start while a result waits to be taken.
module per_key_burst_limiter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    pkbl_req_if.sink                        i_req,
    pkbl_res_if.source                      o_res,
    input  logic                            i_cfg_we,
    input  logic [pkbl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pkbl_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pkbl_pkg::*;

    logic push, full, pop, q_valid;
    t_job push_job, q_job;
    t_cfg cfg;

    // intake, classification and registers
    pkbl_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_full     (full),
        .o_push     (push),
        .o_job      (push_job),
        .o_cfg      (cfg)
    );

    // queue between front and back
    pkbl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    // table search and update
    pkbl_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_job   (q_job),
        .o_pop   (pop),
        .i_cfg   (cfg),
        .o_res   (o_res)
    );

endmodule
